// File: rtl/ivs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared constants, codes and interface types of the indexed vector store.
// ----------------------------------------------------------------------------
package ivs_pkg;

  localparam int Depth     = 256;
  localparam int WordWidth = 32;
  localparam int AddrWidth = $clog2(Depth);
  localparam int CntWidth  = $clog2(Depth + 1);

  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [CntWidth-1:0]  cnt_t;
  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_SET    = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM_HEAD,
    S_SHIFT,
    S_RESP
  } state_e;

  // Access request from the sequencer to the word memory
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // One finished result
  typedef struct packed {
    word_t   word;
    addr_t   slot;
    status_e status;
    cnt_t    fill;
    cnt_t    free;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/indexed_vector_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_vector_store
// Fixed-capacity vector of 256 words of 32 bits with a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_ready_o) carries command_i, position_i
//   and word_in_i. Commands: push, pop, get, set, remove, clear. Every
//   request gives exactly one result on the result channel
//   (out_valid_o / out_ready_i).
//   Push, pop, get, set, clear and any refused request make at most one
//   memory access, in the accept cycle, and then hand the result to the
//   output register. Remove first reads the removed word, then the
//   shift-down sweep moves one word a cycle through the single read and
//   single write port of the memory.
//   One request is in the sequencer at a time; the output register lets the
//   next request enter while a result still waits to be taken.
//   Reset empties the vector at once (fill count zero); memory contents are
//   not cleared and no pass is run. When the receiver stalls, the result is
//   held in the output register and the sequencer holds its next result
//   until the register frees, so no request is accepted in the meantime.
// ----------------------------------------------------------------------------
module indexed_vector_store (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  command_i,
  input  wire  [7:0]  position_i,
  input  wire  [31:0] word_in_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] word_out_o,
  output logic [7:0]  slot_index_o,
  output logic [1:0]  status_o,
  output logic [8:0]  fill_count_o,
  output logic [8:0]  free_slots_o
);

  ivs_pkg::mem_req_t mem_req;
  ivs_pkg::word_t    rdata;
  ivs_pkg::res_t     res;
  logic              res_valid;
  logic              res_ready;

  logic              out_valid_q;
  ivs_pkg::res_t     out_q;

  ivs_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  ivs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .word_in_i   (word_in_i),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_out_o   = 32'(out_q.word);
  assign slot_index_o = 8'(out_q.slot);
  assign status_o     = out_q.status;
  assign fill_count_o = 9'(out_q.fill);
  assign free_slots_o = 9'(out_q.free);

  // one request at a time: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one still in progress");

  // fill and free counts always sum to the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o + free_slots_o) == 9'(ivs_pkg::Depth))
    else $error("fill and free counts inconsistent");

  // a refused push reports all-ones data and the full count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ivs_pkg::ST_FULL |->
      word_out_o == '1 && fill_count_o == 9'(ivs_pkg::Depth))
    else $error("full status with wrong data or count");

  // a stalled result stays valid and unchanged until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_out_o))
    else $error("stalled result lost or changed");

endmodule
`default_nettype wire

// File: rtl/ivs_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_mem
// Word memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ivs_mem (
  input  wire                clk_i,
  input  ivs_pkg::mem_req_t  req_i,
  output ivs_pkg::word_t     rdata_o
);

  ivs_pkg::word_t mem_q [ivs_pkg::Depth];
  ivs_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/ivs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivs_ctrl
// Command sequencer: holds the fill count, issues memory accesses, runs the
// shift-down sweep of remove and builds the result.
// ----------------------------------------------------------------------------
module ivs_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [2:0]         command_i,
  input  wire  [7:0]         position_i,
  input  wire  [31:0]        word_in_i,
  output ivs_pkg::mem_req_t  mem_req_o,
  input  ivs_pkg::word_t     rdata_i,
  output logic               res_valid_o,
  input  wire                res_ready_i,
  output ivs_pkg::res_t      res_o
);

  localparam ivs_pkg::cnt_t CntOne   = ivs_pkg::cnt_t'(1);
  localparam ivs_pkg::cnt_t CntTwo   = ivs_pkg::cnt_t'(2);
  localparam ivs_pkg::cnt_t CntDepth = ivs_pkg::cnt_t'(ivs_pkg::Depth);

  ivs_pkg::state_e  state_q, state_d;
  ivs_pkg::cnt_t    count_q, count_d;
  ivs_pkg::addr_t   idx_q, idx_d;
  ivs_pkg::word_t   word_q, word_d;
  ivs_pkg::addr_t   slot_q, slot_d;
  ivs_pkg::status_e status_q, status_d;
  logic             use_rd_q, use_rd_d;

  ivs_pkg::cmd_e    cmd;
  ivs_pkg::addr_t   pos;
  ivs_pkg::cnt_t    pos_ext;
  ivs_pkg::cnt_t    idx_ext;
  ivs_pkg::cnt_t    last;
  logic             in_range;

  assign cmd      = ivs_pkg::cmd_e'(command_i);
  assign pos      = ivs_pkg::addr_t'(position_i);
  assign pos_ext  = ivs_pkg::cnt_t'(pos);
  assign idx_ext  = ivs_pkg::cnt_t'(idx_q);
  assign last     = count_q - CntOne;
  assign in_range = pos_ext < count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ivs_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    word_q   <= word_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    use_rd_q <= use_rd_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    word_d    = word_q;
    slot_d    = slot_q;
    status_d  = status_q;
    use_rd_d  = use_rd_q;
    mem_req_o = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ivs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          word_d   = '1;
          slot_d   = '0;
          status_d = ivs_pkg::ST_RANGE;
          use_rd_d = 1'b0;
          state_d  = ivs_pkg::S_RESP;
          unique case (cmd)
            ivs_pkg::CMD_PUSH: begin
              if (count_q == CntDepth) begin
                status_d = ivs_pkg::ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = ivs_pkg::addr_t'(count_q);
                mem_req_o.wdata = ivs_pkg::word_t'(word_in_i);
                slot_d   = ivs_pkg::addr_t'(count_q);
                count_d  = count_q + CntOne;
                word_d   = '0;
                status_d = ivs_pkg::ST_OK;
              end
            end
            ivs_pkg::CMD_POP: begin
              if (count_q != '0) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = ivs_pkg::addr_t'(last);
                count_d  = last;
                use_rd_d = 1'b1;
                status_d = ivs_pkg::ST_OK;
              end
            end
            ivs_pkg::CMD_GET: begin
              if (in_range) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = pos;
                use_rd_d = 1'b1;
                status_d = ivs_pkg::ST_OK;
              end
            end
            ivs_pkg::CMD_SET: begin
              if (in_range) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = pos;
                mem_req_o.wdata = ivs_pkg::word_t'(word_in_i);
                word_d   = '0;
                status_d = ivs_pkg::ST_OK;
              end
            end
            ivs_pkg::CMD_REMOVE: begin
              if (in_range) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = pos;
                idx_d    = pos;
                status_d = ivs_pkg::ST_OK;
                state_d  = ivs_pkg::S_REM_HEAD;
              end
            end
            ivs_pkg::CMD_CLEAR: begin
              count_d  = '0;
              word_d   = '0;
              status_d = ivs_pkg::ST_OK;
            end
            default: begin
              // unused command codes: error result, state untouched
            end
          endcase
        end
      end

      ivs_pkg::S_REM_HEAD: begin
        // capture the removed word, then start the shift if anything follows
        word_d = rdata_i;
        if (idx_ext + CntOne < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ivs_pkg::addr_t'(idx_ext + CntOne);
          state_d = ivs_pkg::S_SHIFT;
        end else begin
          count_d = last;
          state_d = ivs_pkg::S_RESP;
        end
      end

      ivs_pkg::S_SHIFT: begin
        // write back one word down while fetching the next
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = rdata_i;
        if (idx_ext + CntTwo < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ivs_pkg::addr_t'(idx_ext + CntTwo);
          idx_d = ivs_pkg::addr_t'(idx_ext + CntOne);
        end else begin
          count_d = last;
          state_d = ivs_pkg::S_RESP;
        end
      end

      ivs_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ivs_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ivs_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.word   = use_rd_q ? rdata_i : word_q;
  assign res_o.slot   = slot_q;
  assign res_o.status = status_q;
  assign res_o.fill   = count_q;
  assign res_o.free   = CntDepth - count_q;

endmodule
`default_nettype wire
